FILE: sv/becs_pkg.sv
// ----------------------------------------------------------------------------
// becs_pkg: shared constants and types of the bit-packed equality count scan
// Geometry of the lane-interleaved block, config register indexes and the
// structs that travel between the position counter, the matcher and the top.
// ----------------------------------------------------------------------------
package becs_pkg;

	// block geometry
	localparam int LANES        = 32;
	localparam int BLOCK_VALUES = 1024;
	localparam int VPL          = BLOCK_VALUES / LANES;

	// field and counter widths
	localparam int WORD_W    = 32;
	localparam int WIDTH_W   = 6;
	localparam int MAX_WIDTH = 32;
	localparam int LANE_W    = $clog2(LANES);
	localparam int ROW_W     = $clog2(VPL);
	localparam int ROWCNT_W  = ROW_W + 1;
	localparam int POS_W     = ROW_W + 5;
	localparam int PROD_W    = $clog2(VPL * 32 + 32) + 1;
	localparam int BLK_W     = $clog2(BLOCK_VALUES + 1);
	localparam int HIT_W     = $clog2(VPL + 1);
	localparam int TOTAL_W   = 64;
	localparam int CFG_IDX_W = 1;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BIT_WIDTH    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MATCH_TARGET = CFG_IDX_W'(1);

	// position of an accepted word within the block
	typedef struct packed {
		logic [LANE_W-1:0] lane;
		logic [ROW_W-1:0]  row;
		logic              ok;    // width is usable
		logic              done;  // word completes the block
	} pos_t;

	// first pipeline stage: word plus its context
	typedef struct packed {
		logic [WORD_W-1:0]  word;
		logic               last;
		pos_t               pos;
		logic [WIDTH_W-1:0] width;
		logic [WORD_W-1:0]  target;
	} s1_t;

	// second pipeline stage: per-value match flags
	typedef struct packed {
		logic [VPL-1:0] hit;
		logic           last;
		logic           done;
	} s2_t;

	function automatic logic width_ok(input logic [WIDTH_W-1:0] b);
		return (b != '0) && (b <= WIDTH_W'(MAX_WIDTH));
	endfunction

endpackage

FILE: sv/becs_in_if.sv
// ----------------------------------------------------------------------------
// becs_in_if: packed word input channel
// Valid/ready channel carrying one packed word and the end-of-scan flag.
// ----------------------------------------------------------------------------
interface becs_in_if import becs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] packed_word;
	logic              last;

	modport source (output valid, output packed_word, output last, input ready);
	modport sink   (input valid, input packed_word, input last, output ready);
endinterface

FILE: sv/becs_out_if.sv
// ----------------------------------------------------------------------------
// becs_out_if: match total output channel
// Valid/ready channel carrying the 64-bit match total of one scan.
// ----------------------------------------------------------------------------
interface becs_out_if import becs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [TOTAL_W-1:0] total_count;

	modport source (output valid, output total_count, input ready);
	modport sink   (input valid, input total_count, output ready);
endinterface

FILE: sv/becs_cfg_if.sv
// ----------------------------------------------------------------------------
// becs_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface becs_cfg_if import becs_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [WORD_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/becs_pos.sv
// ----------------------------------------------------------------------------
// becs_pos: lane and row tracker
// Tracks where the next word falls in the interleaved block and flags the
// word that completes a block for the current width.
// ----------------------------------------------------------------------------
module becs_pos import becs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               last,
	input  logic [WIDTH_W-1:0] bit_width,
	output pos_t               pos
);

	logic [LANE_W-1:0]   lane_q;
	logic [ROW_W-1:0]    row_q;
	logic [PROD_W-1:0]   bits_per_lane;
	logic [ROWCNT_W-1:0] rows;
	logic                lane_end;
	logic                row_end;
	logic                ok;

	// rows per block = ceil(values per lane * width / 32)
	assign bits_per_lane = PROD_W'(VPL) * PROD_W'(bit_width) + PROD_W'(31);
	assign rows          = ROWCNT_W'(bits_per_lane >> 5);
	assign ok            = width_ok(bit_width);
	assign lane_end      = (lane_q == LANE_W'(LANES - 1));
	assign row_end       = ({1'b0, row_q} + ROWCNT_W'(1)) >= rows;

	assign pos.lane = lane_q;
	assign pos.row  = row_q;
	assign pos.ok   = ok;
	assign pos.done = ok && lane_end && row_end;

	// advance lane, then row; end of scan clears both
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_q <= '0;
			row_q  <= '0;
		end else if (accept) begin
			priority if (last) begin
				lane_q <= '0;
				row_q  <= '0;
			end else if (ok && lane_end) begin
				lane_q <= '0;
				row_q  <= row_end ? '0 : row_q + ROW_W'(1);
			end else if (ok) begin
				lane_q <= lane_q + LANE_W'(1);
			end
		end
	end

	a_last_clears_pos: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> lane_q == '0 && row_q == '0)
		else $error("position not cleared after end of scan");

endmodule

FILE: sv/becs_lane_mem.sv
// ----------------------------------------------------------------------------
// becs_lane_mem: previous word store
// One entry per lane holding that lane's last packed word; registered read.
// ----------------------------------------------------------------------------
module becs_lane_mem import becs_pkg::*; (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [LANE_W-1:0] rd_addr,
	output logic [WORD_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [LANE_W-1:0] wr_addr,
	input  logic [WORD_W-1:0] wr_data
);

	logic [WORD_W-1:0] mem [LANES];
	logic [WORD_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: sv/becs_match.sv
// ----------------------------------------------------------------------------
// becs_match: value extract and compare
// For each value slot of a lane, checks whether the value ends in this row,
// funnel-shifts it out of the previous and current words and compares it.
// ----------------------------------------------------------------------------
module becs_match import becs_pkg::*; (
	input  s1_t               s1,
	input  logic [WORD_W-1:0] prev,
	output logic [VPL-1:0]    hit
);

	logic [WORD_W-1:0]   mask;
	logic [2*WORD_W-1:0] pair;
	logic [POS_W-1:0]    start_bit;
	logic [POS_W-1:0]    end_bit;
	logic [5:0]          amt;
	logic [WORD_W-1:0]   val;

	always_comb begin
		mask = (s1.width >= WIDTH_W'(MAX_WIDTH)) ? '1
			: ((WORD_W'(1) << s1.width) - WORD_W'(1));
		pair = {s1.word, prev};
		hit  = '0;
		start_bit = '0;
		end_bit   = '0;
		amt       = '0;
		val       = '0;
		// one slot per value of the lane
		for (int p = 0; p < VPL; p++) begin
			start_bit = POS_W'(p) * POS_W'(s1.width);
			end_bit   = start_bit + POS_W'(s1.width) - POS_W'(1);
			// value starting in this row lies in the current word, the upper half
			// of the pair; one starting in the previous row spans the boundary
			amt       = {start_bit[POS_W-1:5] == s1.pos.row, start_bit[4:0]};
			val       = WORD_W'(pair >> amt);
			hit[p]    = s1.pos.ok && (end_bit[POS_W-1:5] == s1.pos.row)
				&& ((val & mask) == s1.target);
		end
	end

endmodule

FILE: sv/becs_accum.sv
// ----------------------------------------------------------------------------
// becs_accum: match accumulator and result register
// Counts matches per block, folds complete blocks into the 64-bit total and
// holds the total of a finished scan until the receiver takes it.
// ----------------------------------------------------------------------------
module becs_accum import becs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s2_valid,
	input  s2_t                s2,
	input  logic               out_ready,
	output logic               adv,
	output logic               out_valid,
	output logic [TOTAL_W-1:0] total_count
);

	logic [BLK_W-1:0]   block_q;
	logic [TOTAL_W-1:0] total_q;
	logic               out_valid_q;
	logic [TOTAL_W-1:0] out_total_q;
	logic [HIT_W-1:0]   hits;
	logic [BLK_W-1:0]   block_sum;
	logic [TOTAL_W-1:0] total_next;
	logic               fire;

	// count of matching values in this word
	always_comb begin
		hits = '0;
		for (int p = 0; p < VPL; p++) begin
			hits = hits + HIT_W'(s2.hit[p]);
		end
	end

	assign block_sum  = block_q + BLK_W'(hits);
	assign total_next = s2.done ? total_q + TOTAL_W'(block_sum) : total_q;

	// stall only an end-of-scan word while the previous total waits
	assign adv  = !(s2_valid && s2.last && out_valid_q && !out_ready);
	assign fire = s2_valid && adv;

	// block and scan totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_q <= '0;
			total_q <= '0;
		end else if (fire) begin
			if (s2.last) begin
				block_q <= '0;
				total_q <= '0;
			end else begin
				block_q <= s2.done ? '0 : block_sum;
				total_q <= total_next;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && s2.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && s2.last) begin
			out_total_q <= total_next;
		end
	end

	assign out_valid   = out_valid_q;
	assign total_count = out_total_q;

	a_scan_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && s2.last |=> out_valid_q && total_q == '0 && block_q == '0)
		else $error("scan end did not post result and clear counters");

endmodule

FILE: sv/bitpacked_equality_count_scan.sv
// ----------------------------------------------------------------------------
// bitpacked_equality_count_scan: equality count over a bit-packed column
// Counts values equal to a target in a lane-interleaved bit-packed stream.
//
// Channels: cfg writes bit_width (index 0) and match_target (index 1); it is
// always ready; the user must write it only while no scan is in flight, as the
// block does not check this. in_ch takes one packed word per transaction;
// last marks a scan's final word. out_ch gives one total_count per scan, on its last word.
// Throughput: one word per cycle while not stalled. Each word reads its lane's
// previous word from the lane store (one read and one write port) and meets it
// in stage 1 for extract and compare; stage 2 accumulates the match flags.
// Result: the last word of a scan passes stage 1 (read and match) and stage 2,
// then its total is accumulated into the result register.
// Stall: while a total waits on out_ch, words keep flowing; only the next
// last word stops in the accumulate stage and backs the pipeline up.
// Reset: counters, totals and config clear (bit_width to 1, target to 0);
// the lane store is not cleared, as row 0 never reads it.
// ----------------------------------------------------------------------------
module bitpacked_equality_count_scan import becs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	becs_cfg_if.sink  cfg,
	becs_in_if.sink   in_ch,
	becs_out_if.source out_ch
);

	logic [WIDTH_W-1:0] bit_width_q;
	logic [WORD_W-1:0]  match_target_q;
	pos_t               pos;
	logic               accept;
	logic               en0;
	logic               en1;
	logic               adv;
	logic               s1_valid_q;
	s1_t                s1_s1;
	logic               s2_valid_q;
	s2_t                s2_s2;
	logic [WORD_W-1:0]  prev;
	logic [VPL-1:0]     hit;
	logic               wr_en;

	// config registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_width_q    <= WIDTH_W'(1);
			match_target_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_BIT_WIDTH:    bit_width_q    <= cfg.data[WIDTH_W-1:0];
				REG_MATCH_TARGET: match_target_q <= cfg.data;
			endcase
		end
	end

	// stage enables, bubbles collapse ahead of a stalled stage
	assign en1         = adv || !s2_valid_q;
	assign en0         = en1 || !s1_valid_q;
	assign in_ch.ready = en0;
	assign accept      = in_ch.valid && en0;

	becs_pos u_pos (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.last      (in_ch.last),
		.bit_width (bit_width_q),
		.pos       (pos)
	);

	// lane store: read on accept, write back when a word with a usable width leaves stage 1
	assign wr_en = s1_valid_q && en1 && s1_s1.pos.ok;

	becs_lane_mem u_lane_mem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (pos.lane),
		.rd_data (prev),
		.wr_en   (wr_en),
		.wr_addr (s1_s1.pos.lane),
		.wr_data (s1_s1.word)
	);

	// stage 1: word and context
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (en0) begin
			s1_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_s1.word   <= in_ch.packed_word;
			s1_s1.last   <= in_ch.last;
			s1_s1.pos    <= pos;
			s1_s1.width  <= bit_width_q;
			s1_s1.target <= match_target_q;
		end
	end

	becs_match u_match (
		.s1   (s1_s1),
		.prev (prev),
		.hit  (hit)
	);

	// stage 2: match flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (en1) begin
			s2_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && s1_valid_q) begin
			s2_s2.hit  <= hit;
			s2_s2.last <= s1_s1.last;
			s2_s2.done <= s1_s1.pos.done;
		end
	end

	becs_accum u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.s2_valid    (s2_valid_q),
		.s2          (s2_s2),
		.out_ready   (out_ch.ready),
		.adv         (adv),
		.out_valid   (out_ch.valid),
		.total_count (out_ch.total_count)
	);

	a_stall_only_on_output: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> out_ch.valid && !out_ch.ready)
		else $error("input stalled without a pending result");

	a_pipe_full_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> s1_valid_q && s2_valid_q && s2_s2.last)
		else $error("input stalled with room in the pipeline");

endmodule

FILE: verif/bitpacked_equality_count_scan_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitpacked_equality_count_scan_tb: self-checking bench for the packed scan
// Streams lane-interleaved packed columns built from random values, many of
// them equal to the target, through the block under random gaps and stalls.
// A cycle-free model of the scan predicts each total, which is compared
// against every total_count transaction in arrival order.
// ----------------------------------------------------------------------------
module bitpacked_equality_count_scan_tb;
	import becs_pkg::*;

	localparam int          STALL_LIMIT  = 5000;
	localparam int          DRAIN_CYCLES = 8;
	localparam int          END_CYCLES   = 20;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          RANDOM_ITEMS = 450;
	localparam int          MIN_SCANS    = 12;
	localparam int unsigned BITS_PER_LANE = VPL * WORD_W;

	logic clk = 1'b0;
	logic arst_n;

	becs_in_if  word_ch ();
	becs_out_if total_ch ();
	becs_cfg_if cfg_ch ();

	bitpacked_equality_count_scan dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.in_ch  (word_ch),
		.out_ch (total_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// scan model state and its register copies
	bit [WIDTH_W-1:0] cfg_width  = WIDTH_W'(1);
	bit [WORD_W-1:0]  cfg_target = '0;
	bit [WORD_W-1:0]  lane_last_word [LANES];
	int unsigned      cur_row    = 0;
	int unsigned      cur_lane   = 0;
	int unsigned      block_hits = 0;
	bit [TOTAL_W-1:0] scan_total = '0;

	bit [TOTAL_W-1:0] expected_totals [$];
	bit [TOTAL_W-1:0] total_want;
	int unsigned      mismatches = 0;
	int unsigned      words_sent = 0;
	int unsigned      scans_sent = 0;
	int unsigned      stall_cycles = 0;
	bit               back_to_back = 1'b0;

	// receiver hold-off request, counted down in the receiver process
	int unsigned hold_req  = 0;
	int unsigned hold_ack  = 0;
	int unsigned hold_left = 0;

	// packed column of the current block, rebuilt per block or config change
	bit [WORD_W-1:0]  plan_words [BLOCK_VALUES];
	bit [WIDTH_W-1:0] plan_width;
	bit [WORD_W-1:0]  plan_target;
	bit               plan_stale = 1'b1;

	function automatic bit [WORD_W-1:0] value_mask(input int unsigned b);
		return (b >= 32) ? '1 : ((32'd1 << b) - 32'd1);
	endfunction

	// matches among the values whose last bit lies in this lane word
	function automatic int unsigned hits_in_word(input int unsigned row,
			input bit [WORD_W-1:0] cur, input bit [WORD_W-1:0] prev,
			input int unsigned b);
		bit [WORD_W-1:0] mask;
		bit [WORD_W-1:0] v;
		int unsigned     first_bit;
		int unsigned     end_bit;
		int unsigned     off;
		int unsigned     hits;
		mask = value_mask(b);
		hits = 0;
		for (int unsigned p = 0; p < VPL; p++) begin
			first_bit = p * b;
			end_bit = first_bit + b - 1;
			off = first_bit % 32;
			if ((end_bit / 32) != row)
				continue;
			if ((first_bit / 32) == row)
				v = cur >> off;
			else
				v = (prev >> off) | (cur << ((32 - off) % 32));
			if ((v & mask) == cfg_target)
				hits++;
		end
		return hits;
	endfunction

	// advance the scan model by one accepted word
	function automatic void scan_step(input bit [WORD_W-1:0] w, input bit is_last);
		int unsigned b;
		int unsigned rows;
		b = cfg_width;
		if (b >= 1 && b <= 32) begin
			rows = (VPL * b + 31) / 32;
			block_hits += hits_in_word(cur_row, w, lane_last_word[cur_lane], b);
			lane_last_word[cur_lane] = w;
			if (cur_lane + 1 >= LANES) begin
				cur_lane = 0;
				if (cur_row + 1 >= rows) begin
					scan_total += TOTAL_W'(block_hits);
					block_hits = 0;
					cur_row = 0;
					plan_stale = 1'b1;
				end else begin
					cur_row++;
				end
			end else begin
				cur_lane++;
			end
		end
		if (is_last) begin
			expected_totals.push_back(scan_total);
			scan_total = '0;
			block_hits = 0;
			cur_row = 0;
			cur_lane = 0;
			plan_stale = 1'b1;
		end
	endfunction

	// pack one block of values, about half equal to the target, lane by lane
	function automatic void build_plan();
		bit [BITS_PER_LANE-1:0] lane_bits;
		bit [WORD_W-1:0]        mask;
		bit [WORD_W-1:0]        val;
		int unsigned            b;
		b = cfg_width;
		mask = value_mask(b);
		for (int unsigned l = 0; l < LANES; l++) begin
			lane_bits = '0;
			for (int unsigned p = 0; p < VPL; p++) begin
				case ($urandom_range(0, 3))
					0, 1: val = cfg_target & mask;
					2: val = $urandom() & mask;
					default: val = (cfg_target ^ (32'd1 << $urandom_range(0, b - 1))) & mask;
				endcase
				for (int unsigned k = 0; k < b; k++)
					lane_bits[p * b + k] = val[k];
			end
			for (int unsigned w = 0; w < VPL; w++)
				plan_words[w * LANES + l] = lane_bits[w * WORD_W +: WORD_W];
		end
		plan_width = cfg_width;
		plan_target = cfg_target;
		plan_stale = 1'b0;
	endfunction

	// next word of the column, with some noise words mixed in
	function automatic bit [WORD_W-1:0] next_packed_word();
		if (cfg_width < 1 || cfg_width > 32)
			return $urandom();
		if (plan_stale || plan_width != cfg_width || plan_target != cfg_target)
			build_plan();
		if ($urandom_range(0, 99) < 10)
			return $urandom();
		return plan_words[cur_row * LANES + cur_lane];
	endfunction

	function automatic int unsigned gap_cycles();
		int unsigned n;
		n = 0;
		if (back_to_back)
			return 0;
		while ($urandom_range(0, 99) < 29)
			n++;
		return n;
	endfunction

	// mostly narrow widths, some wide ones, a few unusable ones
	function automatic bit [WIDTH_W-1:0] pick_width();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return WIDTH_W'($urandom_range(1, 4));
		if (r < 80)
			return WIDTH_W'($urandom_range(5, 10));
		if (r < 92)
			return WIDTH_W'($urandom_range(11, 32));
		if (r < 96)
			return '0;
		return WIDTH_W'($urandom_range(33, 63));
	endfunction

	function automatic bit [WORD_W-1:0] pick_target();
		bit [WORD_W-1:0] mask;
		mask = (cfg_width >= 1 && cfg_width <= 32) ? value_mask(cfg_width) : '1;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return mask;
			2: return $urandom();
			default: return $urandom() & mask;
		endcase
	endfunction

	// one word transaction, model updated on acceptance
	task automatic send_word(input bit [WORD_W-1:0] w, input bit is_last);
		int unsigned gap;
		gap = gap_cycles();
		if (gap != 0) begin
			word_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		word_ch.valid       <= 1'b1;
		word_ch.packed_word <= w;
		word_ch.last        <= is_last;
		@(posedge clk);
		while (!word_ch.ready)
			@(posedge clk);
		scan_step(w, is_last);
		words_sent++;
		if (is_last)
			scans_sent++;
	endtask

	// wait until every total is back and the pipeline has emptied
	task automatic quiesce();
		word_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_totals.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input bit [WORD_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		if (idx == REG_BIT_WIDTH)
			cfg_width = data[WIDTH_W-1:0];
		else
			cfg_target = data;
		plan_stale = 1'b1;
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// upper data bits are random, only the low six hold the width
	task automatic write_width(input bit [WIDTH_W-1:0] b);
		bit [WORD_W-1:0] r;
		r = $urandom();
		write_reg(REG_BIT_WIDTH, {r[WORD_W-1:WIDTH_W], b});
	endtask

	// a scan of n words, optionally changing the width before word change_at
	task automatic run_scan(input int unsigned n, input int unsigned change_at);
		for (int unsigned i = 0; i < n; i++) begin
			if (change_at != 0 && i == change_at) begin
				quiesce();
				write_width(pick_width());
			end
			send_word(next_packed_word(), i == n - 1);
		end
	endtask

	function automatic int unsigned block_words(input int unsigned b);
		return ((VPL * b + 31) / 32) * LANES;
	endfunction

	// right after reset: width 1, target 0, two scans too short for a block
	task automatic test_reset_partial_block();
		send_word(32'hFFFF_FFFF, 1'b0);
		send_word(32'h0000_0000, 1'b0);
		send_word(32'h5A5A_A5A5, 1'b1);
		send_word($urandom(), 1'b1);
	endtask

	// unusable widths ignore words but still report on the last one
	task automatic test_invalid_widths();
		quiesce();
		write_width('0);
		write_reg(REG_MATCH_TARGET, '0);
		send_word(32'h0000_0000, 1'b0);
		send_word(32'hFFFF_FFFF, 1'b1);
		quiesce();
		write_width(WIDTH_W'(33));
		send_word(32'h0000_0000, 1'b1);
		quiesce();
		write_width('1);
		send_word(32'hFFFF_FFFF, 1'b0);
		send_word(32'h0000_0000, 1'b1);
	endtask

	// widest values and the all-ones target, block left unfinished
	task automatic test_widest_partial();
		quiesce();
		write_width(WIDTH_W'(32));
		write_reg(REG_MATCH_TARGET, 32'hFFFF_FFFF);
		send_word(32'hFFFF_FFFF, 1'b0);
		send_word(32'hFFFF_FFFF, 1'b0);
		send_word(32'h0000_0000, 1'b1);
	endtask

	// one row at width 2, then width 1 makes row 1 finish the block
	task automatic test_width_change_mid_block();
		quiesce();
		write_width(WIDTH_W'(2));
		write_reg(REG_MATCH_TARGET, $urandom_range(0, 3));
		for (int unsigned i = 0; i < LANES; i++)
			send_word(next_packed_word(), 1'b0);
		quiesce();
		write_width(WIDTH_W'(1));
		run_scan(LANES + 4, 0);
	endtask

	// two rows of full-width values, then width 2 makes row 2 finish the block
	task automatic test_widest_block();
		quiesce();
		write_width(WIDTH_W'(32));
		write_reg(REG_MATCH_TARGET, $urandom());
		for (int unsigned i = 0; i < 2 * LANES; i++)
			send_word(next_packed_word(), 1'b0);
		quiesce();
		write_width(WIDTH_W'(2));
		run_scan(LANES + 2, 0);
	endtask

	// receiver holds off while short scans keep coming, so input stalls
	task automatic test_output_backpressure();
		quiesce();
		write_width(WIDTH_W'(1));
		write_reg(REG_MATCH_TARGET, '0);
		hold_req <= hold_req + 1;
		for (int i = 0; i < 30; i++)
			run_scan($urandom_range(1, 3), 0);
	endtask

	// no gaps on either side for a few full-block scans
	task automatic test_back_to_back();
		quiesce();
		back_to_back = 1'b1;
		for (int i = 0; i < 4; i++) begin
			quiesce();
			write_width(WIDTH_W'($urandom_range(1, 3)));
			write_reg(REG_MATCH_TARGET, pick_target());
			run_scan(block_words(cfg_width) + $urandom_range(0, 8), 0);
		end
		back_to_back = 1'b0;
	endtask

	// random scans: mostly whole blocks of narrow values plus a ragged tail
	task automatic test_random_scans();
		int unsigned items_start;
		int unsigned scans_start;
		int unsigned n;
		int unsigned change_at;
		bit [WIDTH_W-1:0] b;
		items_start = words_sent;
		scans_start = scans_sent;
		while (words_sent - items_start < RANDOM_ITEMS || scans_sent - scans_start < MIN_SCANS) begin
			quiesce();
			b = pick_width();
			write_width(b);
			write_reg(REG_MATCH_TARGET, pick_target());
			if (b < 1 || b > 32)
				n = $urandom_range(1, 10);
			else begin
				n = $urandom_range(0, 24);
				if (b <= 2)
					n += $urandom_range(0, 2) * block_words(b);
				else if (b <= 6)
					n += $urandom_range(0, 1) * block_words(b);
			end
			if (n == 0)
				n = 1;
			change_at = (n > 2 && $urandom_range(0, 99) < 12) ? $urandom_range(1, n - 1) : 0;
			run_scan(n, change_at);
		end
	endtask

	// receiver: random ready, long hold-off on request, total checks
	always @(posedge clk) begin
		if (arst_n) begin
			if (total_ch.valid && total_ch.ready) begin
				if (expected_totals.size() == 0) begin
					$error("total_count: no total expected, actual %0d", total_ch.total_count);
					mismatches++;
				end else begin
					total_want = expected_totals.pop_front();
					if (total_ch.total_count !== total_want) begin
						$error("total_count: expected %0d, actual %0d", total_want,
							total_ch.total_count);
						mismatches++;
					end
				end
			end
			if (hold_req != hold_ack) begin
				hold_ack <= hold_req;
				hold_left <= HOLD_CYCLES;
				total_ch.ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				total_ch.ready <= 1'b0;
			end else begin
				total_ch.ready <= back_to_back || ($urandom_range(0, 99) >= 29);
			end
		end else begin
			total_ch.ready <= 1'b0;
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((word_ch.valid && word_ch.ready) || (total_ch.valid && total_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("** bitpacked_equality_count_scan: FAILED **");
			$finish;
		end
	end

	initial begin
		arst_n              <= 1'b0;
		word_ch.valid       <= 1'b0;
		word_ch.packed_word <= '0;
		word_ch.last        <= 1'b0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.index        <= '0;
		cfg_ch.data         <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_partial_block();
		test_invalid_widths();
		test_widest_partial();
		test_width_change_mid_block();
		test_widest_block();
		test_output_backpressure();
		test_back_to_back();
		test_random_scans();

		// drain and report
		quiesce();
		repeat (END_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_totals.size() == 0)
			$display("** bitpacked_equality_count_scan: PASSED **");
		else
			$display("** bitpacked_equality_count_scan: FAILED **");
		$finish;
	end

endmodule
